### rtl/line_delimited_byte_framer_assert.svh
// ----------------------------------------------------------------------------
// Line framer assertion macros
// Shared property forms for the line framer checks.
// ----------------------------------------------------------------------------
`ifndef LINE_DELIMITED_BYTE_FRAMER_ASSERT_SVH
`define LINE_DELIMITED_BYTE_FRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDBF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line framer check failed");

// Consequent must hold in the cycle after the antecedent.
`define LDBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line framer check failed");

`endif

### rtl/ldbf_pkg.sv
// ----------------------------------------------------------------------------
// ldbf_pkg
// Constants, types and helpers shared by the line framer modules.
// ----------------------------------------------------------------------------
package ldbf_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam logic [7:0] BYTE_CR = 8'd13;
    localparam logic [7:0] BYTE_LF = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } ldbf_state_t;

    // CR and LF end a line and are never stored
    function automatic logic is_delim(input logic [7:0] b);
        return (b == BYTE_CR) || (b == BYTE_LF);
    endfunction

endpackage

### rtl/ldbf_ram.sv
// ----------------------------------------------------------------------------
// ldbf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ldbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ldbf_ctrl.sv
// ----------------------------------------------------------------------------
// ldbf_ctrl
// Fill counter and read-out sequencer around the line store.
// ----------------------------------------------------------------------------
module ldbf_ctrl import ldbf_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int LIMIT         = LINE_CAPACITY - 1,
    parameter int AW            = (LIMIT > 1) ? $clog2(LIMIT) : 1,
    parameter int CW            = $clog2(LINE_CAPACITY)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    rx_byte,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          end_of_line,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr
);

    ldbf_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] count_inc;
    logic          last_byte;

    assign count_inc = count_reg + CW'(1);
    assign last_byte = (CW'(rd_idx_reg) + CW'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        end_of_line = last_byte;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_re      = 1'b0;
        ram_raddr   = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (is_delim(rx_byte))
                    begin
                        // a delimiter on an empty line is dropped
                        if (count_reg != '0)
                        begin
                            rd_idx_next = '0;
                            state_next  = ST_FETCH;
                        end
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_inc;
                        if (count_inc == CW'(LIMIT))
                        begin
                            rd_idx_next = '0;
                            state_next  = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_byte)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/line_delimited_byte_framer.sv
// After the item that ends a line, a fetch state comes before the line's first byte is offered.
// Throughput: one item a cycle while gathering; in read-out, each byte is one line-store
// read, then the held output. The sequencer fetches a byte only once the previous one is
// taken, which sets the read-out rate. Reset (rst_n low, asynchronous) empties the line;
// the store is not cleared.
// ----------------------------------------------------------------------------
// line_delimited_byte_framer
// Gathers received bytes into a line store and emits each completed line,
// byte by byte, with the last byte marked.
// ----------------------------------------------------------------------------
`include "line_delimited_byte_framer_assert.svh"

module line_delimited_byte_framer import ldbf_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       end_of_line
);

    // The store holds at most capacity minus one bytes; a line that reaches
    // that length is emitted at once.
    localparam int LIMIT = LINE_CAPACITY - 1;
    localparam int AW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int CW    = $clog2(LINE_CAPACITY);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;

    // Sequencer: counts the bytes of the current line, writes each data
    // item to the store, and on a delimiter or a full line walks the store
    // from entry zero, holding each byte until the sink takes it.
    ldbf_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .LIMIT         (LIMIT),
        .AW            (AW),
        .CW            (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .end_of_line (end_of_line),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    // Line store. Writes and reads never overlap: input is held off for the
    // whole read-out, so no forwarding is needed. The registered read data
    // is the output payload and holds while the sink stalls.
    ldbf_ram #(
        .WIDTH (8),
        .DEPTH (LIMIT),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (line_byte)
    );

    // Gathering and read-out never share a cycle.
    `LDBF_ASSERT_IMPL(a_excl_phase, in_ready, !out_valid)
    // The last byte of a line being taken returns the block to gathering.
    `LDBF_ASSERT_NEXT(a_eol_idle, out_valid && out_ready && end_of_line, in_ready)
    // The store is written only for an accepted data item.
    `LDBF_ASSERT_IMPL(a_store_write, ram_we, in_valid && in_ready && !is_delim(rx_byte))

endmodule
